### rtl/rgb2hsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgb2hsl_pkg;

    // Width of one color channel of the input pixel.
    localparam int CH_W = 8;

    // Width of each result field.
    localparam int FIELD_W = 16;

    // Width of a divider remainder and divisor; six times the largest delta needs 11 bits.
    localparam int DEN_W = 11;

    // Divisor of the lightness fraction: the largest possible max + min.
    localparam int LIGHT_DEN = 510;

    // Half of the lightness range: saturation switches divisors here.
    localparam int HALF_SUM = 255;

    // Divider lanes, one for hue and one for saturation.
    localparam int LANES    = 2;
    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;

endpackage

`default_nettype wire

### rtl/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// RGB to HSL converter for a stream of 8-bit pixels.
// The input channel (s_valid, s_ready, s_red, s_green, s_blue) takes one pixel per beat,
// and the result channel (m_valid, m_ready, m_hue, m_saturation, m_lightness) returns one
// beat per pixel, in order. Each result is an unsigned fraction, floor(x * 2^FRACTION_BITS),
// clamped to all ones at a value of one and cut to 16 bits.
// Throughput is one pixel per clock while the skid register is empty. The pipeline
// registers max and min, then the divider operands, then passes through one
// restoring divider step per fraction bit, shared in lockstep by the hue and saturation
// lanes, and last the output register. Lightness divides by a fixed 510, so it is
// formed in the operand cycle by a multiply with a scaled reciprocal and rides along
// with the lanes.
// Synchronous active-low reset empties every stage and the output; no beat is shown
// until new pixels arrive.
// When the receiver stalls, the result waits in the output register and the pipeline
// keeps moving; one more result is caught in a skid register. Only while that skid
// register is full does the whole pipeline freeze and s_ready go low, so nothing is lost
// or repeated. s_ready comes straight from a register, not from m_ready.
module rgb_to_hsl_converter #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [rgb2hsl_pkg::CH_W-1:0]     s_red,
    input  wire logic [rgb2hsl_pkg::CH_W-1:0]     s_green,
    input  wire logic [rgb2hsl_pkg::CH_W-1:0]     s_blue,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [rgb2hsl_pkg::FIELD_W-1:0]  m_hue,
    output logic      [rgb2hsl_pkg::FIELD_W-1:0]  m_saturation,
    output logic      [rgb2hsl_pkg::FIELD_W-1:0]  m_lightness
);

    import rgb2hsl_pkg::*;

    localparam int NSTG  = FRACTION_BITS + 1;
    localparam int EXT_W = (FRACTION_BITS > FIELD_W) ? FRACTION_BITS : FIELD_W;

    // Lightness is sum * RECIP >> LIG_SHIFT with RECIP = ceil(2^(FRACTION_BITS+LIG_SHIFT)
    // / 510). The rounding error of RECIP times any sum below 510 stays under 2^9, so the
    // product floors to exactly the same value as the true division.
    localparam int LIG_SHIFT = 18;
    localparam int RECIP_W   = FRACTION_BITS + 10;
    localparam int PROD_W    = RECIP_W + CH_W + 1;
    localparam logic [RECIP_W-1:0] LIG_RECIP =
        RECIP_W'(((64'd1 << (FRACTION_BITS + LIG_SHIFT)) + 64'(LIGHT_DEN - 1))
                 / 64'(LIGHT_DEN));

    // Fit a quotient to the output field: zero-extend or keep the low bits.
    function automatic logic [FIELD_W-1:0] to_field(input logic [FRACTION_BITS-1:0] q);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(q);
        return ext[FIELD_W-1:0];
    endfunction

    // The whole pipeline moves together; it holds only while the skid register is full.
    logic pipe_en;
    logic skid_valid_reg;

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    // ------------------------------------------------------------------
    // First stage: register the pixel with its max and min. Red wins ties.
    // ------------------------------------------------------------------
    logic              a_valid_reg;
    logic [CH_W-1:0]   a_r_reg, a_g_reg, a_b_reg, a_mx_reg, a_mn_reg;
    logic [CH_W-1:0]   a_mx_next, a_mn_next;

    always_comb begin
        a_mx_next = s_red;
        if (s_green > a_mx_next) a_mx_next = s_green;
        if (s_blue > a_mx_next)  a_mx_next = s_blue;
        a_mn_next = s_red;
        if (s_green < a_mn_next) a_mn_next = s_green;
        if (s_blue < a_mn_next)  a_mn_next = s_blue;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a_r_reg  <= s_red;
            a_g_reg  <= s_green;
            a_b_reg  <= s_blue;
            a_mx_reg <= a_mx_next;
            a_mn_reg <= a_mn_next;
        end
    end

    // ------------------------------------------------------------------
    // Operand stage: numerators and divisors of the hue and saturation
    // fractions, and the finished lightness.
    // ------------------------------------------------------------------
    logic [CH_W-1:0]    delta;
    logic [CH_W:0]      sum;
    logic [DEN_W-1:0]   six_d;
    logic [DEN_W-1:0]   hue_num;
    logic [CH_W:0]      sat_den;
    logic               grey, sat_full, lig_full;
    logic [PROD_W-1:0]  lig_prod;
    logic [FIELD_W-1:0] lig_field;

    always_comb begin
        delta = a_mx_reg - a_mn_reg;
        sum   = {1'b0, a_mx_reg} + {1'b0, a_mn_reg};
        six_d = DEN_W'({delta, 2'b00}) + DEN_W'({delta, 1'b0});

        // Hue numerator over six times delta, kept within one turn.
        if (a_r_reg == a_mx_reg) begin
            if (a_g_reg >= a_b_reg) begin
                hue_num = DEN_W'(a_g_reg - a_b_reg);
            end else begin
                hue_num = six_d - DEN_W'(a_b_reg - a_g_reg);
            end
        end else if (a_g_reg == a_mx_reg) begin
            hue_num = DEN_W'({delta, 1'b0}) + DEN_W'(a_b_reg) - DEN_W'(a_r_reg);
        end else begin
            hue_num = DEN_W'({delta, 2'b00}) + DEN_W'(a_r_reg) - DEN_W'(a_g_reg);
        end

        if (sum < (CH_W + 1)'(HALF_SUM)) begin
            sat_den  = sum;
            sat_full = (a_mn_reg == '0);
        end else begin
            sat_den  = (CH_W + 1)'(LIGHT_DEN) - sum;
            sat_full = (a_mx_reg == '1);
        end

        grey     = (delta == '0);
        lig_full = (sum == (CH_W + 1)'(LIGHT_DEN));

        lig_prod  = PROD_W'(sum) * PROD_W'(LIG_RECIP);
        lig_field = lig_full ? to_field('1)
                             : to_field(lig_prod[LIG_SHIFT +: FRACTION_BITS]);
    end

    // ------------------------------------------------------------------
    // Divider pipeline: stage 0 holds the operands, each later stage
    // produces one quotient bit per lane.
    // ------------------------------------------------------------------
    logic [NSTG-1:0]          vld_reg;
    logic [NSTG-1:0]          grey_reg, sat_full_reg;
    logic [FIELD_W-1:0]       lig_reg [NSTG];
    logic [DEN_W-1:0]         rem_reg [NSTG][LANES];
    logic [DEN_W-1:0]         den_reg [NSTG][LANES];
    logic [FRACTION_BITS-1:0] q_reg   [NSTG][LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (pipe_en) begin
            vld_reg[0] <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rem_reg[0][LANE_HUE] <= hue_num;
            den_reg[0][LANE_HUE] <= six_d;
            rem_reg[0][LANE_SAT] <= DEN_W'(delta);
            den_reg[0][LANE_SAT] <= DEN_W'(sat_den);
            for (int l = 0; l < LANES; l++) begin
                q_reg[0][l] <= '0;
            end
            grey_reg[0]     <= grey;
            sat_full_reg[0] <= sat_full;
            lig_reg[0]      <= lig_field;
        end
    end

    for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_div
        logic [DEN_W:0]           two     [LANES];
        logic                     ge      [LANES];
        logic [DEN_W-1:0]         rem_next[LANES];
        logic [FRACTION_BITS-1:0] q_next  [LANES];

        // Restoring step: double the remainder, subtract the divisor if it fits.
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                two[l]      = {rem_reg[k][l], 1'b0};
                ge[l]       = (two[l] >= {1'b0, den_reg[k][l]});
                rem_next[l] = ge[l] ? DEN_W'(two[l] - {1'b0, den_reg[k][l]})
                                    : two[l][DEN_W-1:0];
                q_next[l]   = {q_reg[k][l][FRACTION_BITS-2:0], ge[l]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (pipe_en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[k+1][l] <= rem_next[l];
                    den_reg[k+1][l] <= den_reg[k][l];
                    q_reg[k+1][l]   <= q_next[l];
                end
                grey_reg[k+1]     <= grey_reg[k];
                sat_full_reg[k+1] <= sat_full_reg[k];
                lig_reg[k+1]      <= lig_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result forming: grey pixels have no hue or saturation, and a value
    // of exactly one clamps to all ones.
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0] hue_next, sat_next, lig_next;

    always_comb begin
        if (grey_reg[NSTG-1]) begin
            hue_next = '0;
            sat_next = '0;
        end else begin
            hue_next = to_field(q_reg[NSTG-1][LANE_HUE]);
            sat_next = sat_full_reg[NSTG-1] ? to_field('1)
                                            : to_field(q_reg[NSTG-1][LANE_SAT]);
        end
        lig_next = lig_reg[NSTG-1];
    end

    // ------------------------------------------------------------------
    // Output register with a one-beat skid register behind it.
    // ------------------------------------------------------------------
    logic               out_valid_reg;
    logic [FIELD_W-1:0] out_hue_reg, out_sat_reg, out_lig_reg;
    logic [FIELD_W-1:0] skid_hue_reg, skid_sat_reg, skid_lig_reg;
    logic               leave;
    logic               to_out;

    // A result leaves the last divider stage whenever the pipeline moves.
    assign leave  = pipe_en && vld_reg[NSTG-1];
    assign to_out = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (leave) begin
            if (to_out) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_hue_reg <= skid_hue_reg;
                out_sat_reg <= skid_sat_reg;
                out_lig_reg <= skid_lig_reg;
            end
        end else if (leave) begin
            if (to_out) begin
                out_hue_reg <= hue_next;
                out_sat_reg <= sat_next;
                out_lig_reg <= lig_next;
            end else begin
                skid_hue_reg <= hue_next;
                skid_sat_reg <= sat_next;
                skid_lig_reg <= lig_next;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hue        = out_hue_reg;
    assign m_saturation = out_sat_reg;
    assign m_lightness  = out_lig_reg;

endmodule

`default_nettype wire

### verif/tb_rgb_to_hsl_converter.sv
`timescale 1ns / 1ps

// This testbench checks the RGB to HSL converter end to end. Pixels go in on the s_ side,
// one per beat. For each accepted beat, a predictor inside the bench works out the exact
// hue, saturation and lightness fractions and queues them. A checker takes each result
// beat from the m_ side and compares it field by field with the oldest queued
// expectation. Both sides idle at random so that gaps land on every stage of the divider
// pipeline. Some stretches run with no idling at all, so that full throughput is also
// covered.
module tb_rgb_to_hsl_converter;

    import rgb2hsl_pkg::*;

    localparam int FRAC_BITS = 16;

    // Time an accepted pixel takes to reach the m_ side, used for the final wait.
    localparam int PIPE_LATENCY = FRAC_BITS + 3;

    // The slowest correct run is about 475 pixels. Each one can take the longest input
    // gap and some of the longest output stalls, which stays well within CYCLE_LIMIT.
    localparam int CYCLE_LIMIT = 400000;

    localparam int RANDOM_PIXELS = 450;
    localparam int CHUNK_PIXELS  = 50;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [FIELD_W-1:0] hue;
        logic [FIELD_W-1:0] saturation;
        logic [FIELD_W-1:0] lightness;
    } hsl_pixel_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [CH_W-1:0]    s_red;
    logic [CH_W-1:0]    s_green;
    logic [CH_W-1:0]    s_blue;
    logic               m_valid;
    logic               m_ready;
    logic [FIELD_W-1:0] m_hue;
    logic [FIELD_W-1:0] m_saturation;
    logic [FIELD_W-1:0] m_lightness;

    // Expected results, oldest first, one for each pixel that was accepted.
    hsl_pixel_t expected_hsl_q[$];

    int  mismatch_count;
    bit  tx_idle_on;
    bit  rx_stall_on;

    rgb_to_hsl_converter #(
        .FRACTION_BITS(FRAC_BITS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hue       (m_hue),
        .m_saturation(m_saturation),
        .m_lightness (m_lightness)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // This computes floor(num * 2^FRAC_BITS / den) in exact integer arithmetic. A value
    // of one or more clamps to all ones. A zero divisor gives zero. The caller cuts the
    // result to the field width.
    function automatic longint unsigned scaled_fraction(longint unsigned num,
                                                        longint unsigned den);
        longint unsigned one;
        longint unsigned q;
        one = longint'(1) << FRAC_BITS;
        if (den == 0)
            return 0;
        q = (num << FRAC_BITS) / den;
        if (q > one - 1)
            q = one - 1;
        return q;
    endfunction

    // This is the predictor. It gives the exact HSL fractions of one pixel.
    function automatic hsl_pixel_t convert_rgb_to_hsl(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                                      logic [CH_W-1:0] b);
        longint unsigned rr, gg, bb, top, bottom, spread, total, wheel;
        hsl_pixel_t res;
        rr = 64'(r);
        gg = 64'(g);
        bb = 64'(b);
        top = rr;
        if (gg > top) top = gg;
        if (bb > top) top = bb;
        bottom = rr;
        if (gg < bottom) bottom = gg;
        if (bb < bottom) bottom = bb;
        spread = top - bottom;
        total  = top + bottom;

        res.hue        = '0;
        res.saturation = '0;
        res.lightness  = FIELD_W'(scaled_fraction(total, 64'(LIGHT_DEN)));

        // A grey pixel has no hue and no saturation.
        if (spread != 0) begin
            if (total < HALF_SUM)
                res.saturation = FIELD_W'(scaled_fraction(spread, total));
            else
                res.saturation = FIELD_W'(scaled_fraction(spread, 2 * HALF_SUM - total));

            // The position on the wheel is taken in units of 1/(6*spread) of a turn. Red
            // wins ties over green, and green wins over blue. In the red sector, a
            // negative offset wraps around by one full turn.
            if (rr == top) begin
                if (gg >= bb)
                    wheel = gg - bb;
                else
                    wheel = 6 * spread - (bb - gg);
            end else if (gg == top) begin
                wheel = 2 * spread + bb - rr;
            end else begin
                wheel = 4 * spread + rr - gg;
            end
            res.hue = FIELD_W'(scaled_fraction(wheel, 6 * spread));
        end
        return res;
    endfunction

    // Most gaps are zero or short, and a few are long. A chunk with idling turned off
    // runs back to back.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // This sends one pixel and queues its prediction when the beat is taken. Valid stays
    // high from one pixel to the next when there is no gap, so it is never lowered and
    // raised again in the same time step.
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red   <= r;
        s_green <= g;
        s_blue  <= b;
        // Values read right after the edge are still the ones from before it, so a
        // high s_ready here means the beat was taken at this edge.
        do
            @(posedge aclk);
        while (!s_ready);
        expected_hsl_q.push_back(convert_rgb_to_hsl(r, g, b));
    endtask

    task automatic test_extremes();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        // These have the smallest nonzero spread, at both ends of the range.
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd1,   8'd0,   8'd0);
    endtask

    task automatic test_grey();
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd127, 8'd127, 8'd127);
        send_pixel(8'd128, 8'd128, 8'd128);
    endtask

    task automatic test_max_ties();
        send_pixel(8'd200, 8'd200, 8'd50);
        send_pixel(8'd200, 8'd50,  8'd200);
        send_pixel(8'd50,  8'd200, 8'd200);
    endtask

    task automatic test_hue_sectors();
        send_pixel(8'd200, 8'd100, 8'd50);
        // In the red sector with blue above green, the hue wraps to just below one turn.
        send_pixel(8'd200, 8'd50,  8'd100);
        send_pixel(8'd50,  8'd200, 8'd100);
        send_pixel(8'd100, 8'd50,  8'd200);
    endtask

    // The saturation divisor switches where max + min crosses half the range.
    task automatic test_saturation_split();
        send_pixel(8'd200, 8'd54, 8'd100);
        send_pixel(8'd200, 8'd55, 8'd100);
        send_pixel(8'd200, 8'd56, 8'd100);
    endtask

    // This picks a channel value from the very ends of the range.
    function automatic logic [CH_W-1:0] edge_level();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // Most random pixels are fully random. The rest are weighted toward grey pixels,
    // ties for the maximum and the ends of the range, which random draws rarely hit.
    task automatic test_random_pixels();
        logic [CH_W-1:0] r, g, b, level;
        int kind;
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if (n % CHUNK_PIXELS == 0) begin
                tx_idle_on  = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
            end
            r = CH_W'($urandom_range(0, 255));
            g = CH_W'($urandom_range(0, 255));
            b = CH_W'($urandom_range(0, 255));
            kind = $urandom_range(0, 9);
            level = CH_W'($urandom_range(0, 255));
            case (kind)
                0: begin
                    r = level;
                    g = level;
                    b = level;
                end
                1: begin
                    case ($urandom_range(0, 2))
                        0: g = r;
                        1: b = r;
                        default: b = g;
                    endcase
                end
                2: begin
                    r = edge_level();
                    g = edge_level();
                    b = edge_level();
                end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    // This is the receiver. It holds ready for runs of random length. While stalling is
    // on, it drops ready now and then, mostly briefly and sometimes for a long stretch.
    initial begin
        int hold;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (rx_stall_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
            end else begin
                m_ready <= 1'b1;
                hold = $urandom_range(1, 8);
            end
            repeat (hold) @(posedge aclk);
        end
    end

    // This is the checker. A beat moves on any edge where m_valid and m_ready were both
    // high just before it.
    always @(posedge aclk) begin
        hsl_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_hsl_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result beat with no pixel pending: hue %h sat %h lig %h",
                             $realtime, m_hue, m_saturation, m_lightness);
            end else begin
                want = expected_hsl_q.pop_front();
                if (m_hue !== want.hue || m_saturation !== want.saturation ||
                    m_lightness !== want.lightness) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: mismatch: hue %h/%h sat %h/%h lig %h/%h (exp/act)",
                                 $realtime, want.hue, m_hue, want.saturation, m_saturation,
                                 want.lightness, m_lightness);
                end
            end
        end
    end

    // This is the watchdog. A hung handshake ends the run here.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        tx_idle_on     = 1'b1;
        rx_stall_on    = 1'b1;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_red   <= '0;
        s_green <= '0;
        s_blue  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_grey();
        test_max_ties();
        test_hue_sectors();
        test_saturation_split();
        test_random_pixels();
        s_valid <= 1'b0;

        // This drains the pipeline and then waits a little longer, so that a stray extra
        // beat is still caught.
        while (expected_hsl_q.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 8) @(posedge aclk);

        if (expected_hsl_q.size() != 0) begin
            mismatch_count++;
            $display("%0d expected results never arrived", expected_hsl_q.size());
        end

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
